// ===== hw/rtl/waypoint_turn_then_drive_steps_macros.svh =====
// Assertion macros for the waypoint turn-then-drive block.
// Depends on nothing; included by the files that carry assertions.
`ifndef WAYPOINT_TURN_THEN_DRIVE_STEPS_MACROS_SVH
`define WAYPOINT_TURN_THEN_DRIVE_STEPS_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define WTDS_ASSERT_IMP(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("wtds assertion failed");
// next-cycle implication
`define WTDS_ASSERT_NXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("wtds assertion failed");
`else
`define WTDS_ASSERT_IMP(lbl, ck, rst_n, ante, cons)
`define WTDS_ASSERT_NXT(lbl, ck, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/wtds_pkg.sv =====
// Shared constants, types and the CORDIC arctangent table.
// Depends on nothing.
package wtds_pkg;
	localparam int COORD_WIDTH       = 16;
	localparam int ANGLE_WIDTH       = 16;
	localparam int CORDIC_ITERATIONS = 16;

	localparam int DIFF_W    = COORD_WIDTH + 1;
	localparam int PRESCALE  = 58 - COORD_WIDTH;
	localparam int CORDIC_W  = 62;
	localparam int ACC_W     = 36;
	localparam int ITER_W    = $clog2(CORDIC_ITERATIONS + 1);
	localparam int RAD_W     = 2 * DIFF_W;
	localparam int ROOT_W    = DIFF_W + 16;
	localparam int REM_W     = ROOT_W + 3;
	localparam int SQRT_STEPS = ROOT_W;
	localparam int SQRT_CNT_W = $clog2(SQRT_STEPS + 1);

	localparam int SPM_W   = 24;
	localparam int TRACK_W = 10;
	localparam int STEPS_W = 32;
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 31;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam logic [MUL_B_W-1:0] PI_Q29 = 31'd1686629713;
	localparam logic [SPM_W-1:0]   SPM_RESET   = 24'd65536;
	localparam logic [TRACK_W-1:0] TRACK_RESET = 10'd223;

	// configuration register indexes
	localparam logic REG_STEPS_PER_MM = 1'b0;
	localparam logic REG_TRACK_WIDTH  = 1'b1;

	typedef struct packed {
		logic                   done;
		logic [ANGLE_WIDTH-1:0] angle;
	} cordic_res_t;

	typedef struct packed {
		logic              done;
		logic [ROOT_W-1:0] root;
	} sqrt_res_t;

	// atan(2^-i) in 2^-32 turn units
	function automatic logic signed [ACC_W-1:0] atan_turn(input logic [ITER_W-1:0] i);
		logic [31:0] r;
		unique case (5'(i))
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051D;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2E;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2F9;
			5'd15: r = 32'h0000517C;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A2F;
			5'd19: r = 32'h00000517;
			5'd20: r = 32'h0000028B;
			5'd21: r = 32'h00000145;
			5'd22: r = 32'h000000A2;
			5'd23: r = 32'h00000051;
			default: r = 32'h0;
		endcase
		return $signed({{(ACC_W-32){1'b0}}, r});
	endfunction
endpackage

// ===== hw/rtl/wtds_goal_if.sv =====
// Goal point channel: valid/ready handshake with goal coordinates.
// Depends on nothing.
interface wtds_goal_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] goal_x;
	logic signed [15:0] goal_y;
	modport source (output valid, goal_x, goal_y, input ready);
	modport sink (input valid, goal_x, goal_y, output ready);
endinterface

// ===== hw/rtl/wtds_cmd_if.sv =====
// Motor command channel: valid/ready handshake with wheel step counts.
// Depends on nothing.
interface wtds_cmd_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] left_steps;
	logic signed [31:0] right_steps;
	logic               is_advance;
	modport source (output valid, left_steps, right_steps, is_advance, input ready);
	modport sink (input valid, left_steps, right_steps, is_advance, output ready);
endinterface

// ===== hw/rtl/wtds_mul.sv =====
// Shared unsigned multiplier with a registered product.
// Depends on wtds_pkg.
module wtds_mul (
	input  logic                          clk,
	input  logic [wtds_pkg::MUL_A_W-1:0]  a,
	input  logic [wtds_pkg::MUL_B_W-1:0]  b,
	output logic [wtds_pkg::MUL_P_W-1:0]  p
);
	// register the product
	always_ff @(posedge clk) begin
		p <= wtds_pkg::MUL_P_W'(a) * wtds_pkg::MUL_P_W'(b);
	end
endmodule

// ===== hw/rtl/wtds_cordic.sv =====
// Iterative vectoring CORDIC: bearing of (dx, dy) measured from +y toward +x.
// Depends on wtds_pkg.
module wtds_cordic (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [wtds_pkg::DIFF_W-1:0] dx,
	input  logic signed [wtds_pkg::DIFF_W-1:0] dy,
	output wtds_pkg::cordic_res_t              res
);
	localparam int CW = wtds_pkg::CORDIC_W;
	localparam int AW = wtds_pkg::ACC_W;
	localparam int NW = wtds_pkg::ANGLE_WIDTH;

	logic                             busy_q;
	logic [wtds_pkg::ITER_W-1:0]      idx_q;
	logic signed [CW-1:0]             u_q, v_q;
	logic signed [AW-1:0]             acc_q;
	logic signed [CW-1:0]             u0, v0, du, dv;
	logic signed [AW-1:0]             rnd;

	assign u0 = CW'(dy) <<< wtds_pkg::PRESCALE;
	assign v0 = CW'(dx) <<< wtds_pkg::PRESCALE;
	assign du = v_q >>> idx_q;
	assign dv = u_q >>> idx_q;

	// sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q) begin
			idx_q <= idx_q + 1'b1;
			if (idx_q == wtds_pkg::ITER_W'(wtds_pkg::CORDIC_ITERATIONS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// load with quarter-turn pre-rotation, then rotate toward v = 0
	always_ff @(posedge clk) begin
		if (start) begin
			if (u0 < 0) begin
				if (v0 >= 0) begin
					u_q   <= v0;
					v_q   <= -u0;
					acc_q <= AW'(64'sd1 <<< 30);
				end else begin
					u_q   <= -v0;
					v_q   <= u0;
					acc_q <= -AW'(64'sd1 <<< 30);
				end
			end else begin
				u_q   <= u0;
				v_q   <= v0;
				acc_q <= '0;
			end
		end else if (busy_q) begin
			if (v_q >= 0) begin
				u_q   <= u_q + du;
				v_q   <= v_q - dv;
				acc_q <= acc_q + wtds_pkg::atan_turn(idx_q);
			end else begin
				u_q   <= u_q - du;
				v_q   <= v_q + dv;
				acc_q <= acc_q - wtds_pkg::atan_turn(idx_q);
			end
		end
	end

	// round half up to the angle width
	assign rnd       = acc_q + AW'(64'sd1 <<< (31 - NW));
	assign res.angle = rnd[31:32-NW];
	assign res.done  = !busy_q;
endmodule

// ===== hw/rtl/wtds_sqrt.sv =====
// Bit-serial square root: floor(sqrt(rad) * 2^16), two radicand bits a cycle.
// Depends on wtds_pkg.
module wtds_sqrt (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [wtds_pkg::RAD_W-1:0]      rad,
	output wtds_pkg::sqrt_res_t             res
);
	localparam int RW = wtds_pkg::ROOT_W;
	localparam int MW = wtds_pkg::REM_W;
	localparam int SW = 2 * RW;

	logic                              busy_q;
	logic [wtds_pkg::SQRT_CNT_W-1:0]   cnt_q;
	logic [SW-1:0]                     rad_q;
	logic [RW-1:0]                     root_q;
	logic [MW-1:0]                     rem_q;
	logic [MW-1:0]                     rem_n, trial;

	assign rem_n = {rem_q[MW-3:0], rad_q[SW-1:SW-2]};
	assign trial = MW'({root_q, 2'b01});

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == wtds_pkg::SQRT_CNT_W'(wtds_pkg::SQRT_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// one root bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= SW'(rad) << 32;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			rad_q <= rad_q << 2;
			if (rem_n >= trial) begin
				rem_q  <= rem_n - trial;
				root_q <= {root_q[RW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_n;
				root_q <= {root_q[RW-2:0], 1'b0};
			end
		end
	end

	assign res.root = root_q;
	assign res.done = !busy_q;
endmodule

// ===== hw/rtl/waypoint_turn_then_drive_steps.sv =====
// Waypoint turn-then-drive block: sequencer, pose, configuration and output register.
// Depends on wtds_pkg, wtds_goal_if, wtds_cmd_if, wtds_mul, wtds_cordic, wtds_sqrt
// and the assertion macro header.
//
// Usage: each transfer on the goal channel carries one goal point in millimetres. The
// block answers with two transfers on the cmd channel: a rotation (is_advance 0, left and
// right of opposite sign) and then an advance (is_advance 1, both wheels equal). The pose
// then moves to the goal and the heading to the new bearing.
// Timing: goal ready is high only while idle. After a goal transfer the setup states
// START, SQY and ROOT run, then the 33-step square root (the CORDIC, 16 steps, runs
// beside it), then MTRK to CAPA on the shared multiplier; the rotation command is then
// offered, and the advance once the rotation has transferred. A new goal can be taken the
// cycle after the advance transfer, so no goal is taken before both commands are out.
// Stall: while cmd ready is low the pending command is held on the port unchanged and
// no goal is taken.
// Reset: pose and heading clear to zero, steps_per_mm to 1.0 (Q8.16) and track width
// to 223 mm. Configuration writes go in through cfg_we/cfg_index/cfg_data; the user
// must make them only while idle, as the block itself does not enforce it.
`include "waypoint_turn_then_drive_steps_macros.svh"
module waypoint_turn_then_drive_steps (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [wtds_pkg::SPM_W-1:0]   cfg_data,
	wtds_goal_if.sink                    goal,
	wtds_cmd_if.source                   cmd
);
	localparam int DW = wtds_pkg::DIFF_W;
	localparam int NW = wtds_pkg::ANGLE_WIDTH;
	localparam int CWD = wtds_pkg::COORD_WIDTH;
	localparam int AW = wtds_pkg::MUL_A_W;
	localparam int BW = wtds_pkg::MUL_B_W;
	localparam int PW = wtds_pkg::MUL_P_W;
	localparam int MT_W = NW + 1 + wtds_pkg::TRACK_W;
	localparam int B_W = MT_W + wtds_pkg::SPM_W;
	localparam int MID_W = B_W;
	localparam int S_W = MID_W - (NW + 13);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_START = 4'd1;
	localparam logic [3:0] ST_SQY   = 4'd2;
	localparam logic [3:0] ST_ROOT  = 4'd3;
	localparam logic [3:0] ST_WAIT  = 4'd4;
	localparam logic [3:0] ST_MTRK  = 4'd5;
	localparam logic [3:0] ST_MSPM  = 4'd6;
	localparam logic [3:0] ST_MPHI  = 4'd7;
	localparam logic [3:0] ST_MPLO  = 4'd8;
	localparam logic [3:0] ST_MADV  = 4'd9;
	localparam logic [3:0] ST_CAPA  = 4'd10;
	localparam logic [3:0] ST_OUTR  = 4'd11;
	localparam logic [3:0] ST_OUTA  = 4'd12;

	logic [3:0]                    state_q;
	logic [wtds_pkg::SPM_W-1:0]    spm_q;
	logic [wtds_pkg::TRACK_W-1:0]  trk_q;
	logic signed [CWD-1:0]         pose_x_q, pose_y_q;
	logic [NW-1:0]                 heading_q;
	logic signed [CWD-1:0]         gx_q, gy_q;
	logic signed [DW-1:0]          dx_q, dy_q;
	logic [PW-1:0]                 sx_q;
	logic [NW-1:0]                 turn_q;
	logic [B_W-1:0]                b_q;
	logic [PW-1:0]                 p1_q;
	logic [S_W-1:0]                s_q;
	logic [wtds_pkg::STEPS_W-1:0]  adv_q;

	logic [AW-1:0]                 mul_a;
	logic [BW-1:0]                 mul_b;
	logic [PW-1:0]                 prod;
	logic [DW-1:0]                 ax, ay;
	logic [NW:0]                   mag;
	logic [NW-1:0]                 turn_n;
	logic [MID_W-1:0]              mid;
	logic signed [wtds_pkg::STEPS_W-1:0] rot_r;
	wtds_pkg::cordic_res_t         cres;
	wtds_pkg::sqrt_res_t           sres;
	logic                          go_xfer, cmd_xfer;

	assign go_xfer  = goal.valid && goal.ready;
	assign cmd_xfer = cmd.valid && cmd.ready;

	assign ax  = dx_q[DW-1] ? DW'(-dx_q) : DW'(dx_q);
	assign ay  = dy_q[DW-1] ? DW'(-dy_q) : DW'(dy_q);
	assign mag = turn_q[NW-1] ? (NW+1)'(0) - {turn_q[NW-1], turn_q} : {1'b0, turn_q};
	assign mid = MID_W'(p1_q) + MID_W'(prod[PW-1:32]);

	// turn from bearing and heading; zero offset keeps the heading
	always_comb begin
		if (dx_q == '0 && dy_q == '0) begin
			turn_n = '0;
		end else begin
			turn_n = NW'(0) - cres.angle - heading_q;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spm_q <= wtds_pkg::SPM_RESET;
			trk_q <= wtds_pkg::TRACK_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wtds_pkg::REG_STEPS_PER_MM: spm_q <= cfg_data;
				wtds_pkg::REG_TRACK_WIDTH:  trk_q <= cfg_data[wtds_pkg::TRACK_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and pose
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pose_x_q  <= '0;
			pose_y_q  <= '0;
			heading_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE:  if (go_xfer) state_q <= ST_START;
				ST_START: state_q <= ST_SQY;
				ST_SQY:   state_q <= ST_ROOT;
				ST_ROOT:  state_q <= ST_WAIT;
				ST_WAIT:  if (cres.done && sres.done) state_q <= ST_MTRK;
				ST_MTRK:  state_q <= ST_MSPM;
				ST_MSPM:  state_q <= ST_MPHI;
				ST_MPHI:  state_q <= ST_MPLO;
				ST_MPLO:  state_q <= ST_MADV;
				ST_MADV:  state_q <= ST_CAPA;
				ST_CAPA:  state_q <= ST_OUTR;
				ST_OUTR:  if (cmd.ready) state_q <= ST_OUTA;
				ST_OUTA: begin
					if (cmd.ready) begin
						state_q   <= ST_IDLE;
						pose_x_q  <= gx_q;
						pose_y_q  <= gy_q;
						heading_q <= heading_q + turn_q;
					end
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && go_xfer) begin
			gx_q <= goal.goal_x[CWD-1:0];
			gy_q <= goal.goal_y[CWD-1:0];
			dx_q <= DW'($signed(goal.goal_x[CWD-1:0])) - DW'(pose_x_q);
			dy_q <= DW'($signed(goal.goal_y[CWD-1:0])) - DW'(pose_y_q);
		end
		if (state_q == ST_SQY) sx_q <= prod;
		if (state_q == ST_WAIT) turn_q <= turn_n;
		if (state_q == ST_MPHI) b_q <= prod[B_W-1:0];
		if (state_q == ST_MPLO) p1_q <= prod;
		if (state_q == ST_MADV) s_q <= mid[MID_W-1:NW+13];
		if (state_q == ST_CAPA) begin
			adv_q <= prod[PW-1] ? 32'h7FFF_FFFF : prod[PW-1:32];
		end
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_START: begin mul_a = AW'(ax); mul_b = BW'(ax); end
			ST_SQY:   begin mul_a = AW'(ay); mul_b = BW'(ay); end
			ST_MTRK:  begin mul_a = AW'(mag); mul_b = BW'(trk_q); end
			ST_MSPM:  begin mul_a = AW'(prod[MT_W-1:0]); mul_b = BW'(spm_q); end
			ST_MPHI:  begin mul_a = AW'(prod[B_W-1:32]); mul_b = wtds_pkg::PI_Q29; end
			ST_MPLO:  begin mul_a = AW'(b_q[31:0]); mul_b = wtds_pkg::PI_Q29; end
			ST_MADV:  begin mul_a = AW'(sres.root); mul_b = BW'(spm_q); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	wtds_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	wtds_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_START),
		.dx     (dx_q),
		.dy     (dy_q),
		.res    (cres)
	);

	wtds_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_ROOT),
		.rad    (wtds_pkg::RAD_W'(sx_q) + wtds_pkg::RAD_W'(prod)),
		.res    (sres)
	);

	// drive the command port from held registers
	assign rot_r = turn_q[NW-1] ? -$signed(32'(s_q)) : $signed(32'(s_q));
	assign goal.ready      = (state_q == ST_IDLE);
	assign cmd.valid       = (state_q == ST_OUTR) || (state_q == ST_OUTA);
	assign cmd.is_advance  = (state_q == ST_OUTA);
	assign cmd.left_steps  = (state_q == ST_OUTA) ? $signed(adv_q) : -rot_r;
	assign cmd.right_steps = (state_q == ST_OUTA) ? $signed(adv_q) : rot_r;

	`WTDS_ASSERT_IMP(a_no_cmd_when_idle, clk, arst_n, goal.ready, !cmd.valid)
	`WTDS_ASSERT_NXT(a_adv_follows_rot, clk, arst_n, cmd_xfer && !cmd.is_advance, cmd.valid && cmd.is_advance)
	`WTDS_ASSERT_NXT(a_idle_after_adv, clk, arst_n, cmd_xfer && cmd.is_advance, goal.ready)
	`WTDS_ASSERT_IMP(a_rot_opposite, clk, arst_n, cmd.valid && !cmd.is_advance, cmd.left_steps == -cmd.right_steps)
endmodule

// ===== tb/waypoint_turn_then_drive_steps_tb.sv =====
// Self-checking testbench for the waypoint turn-then-drive block.
// Depends on wtds_pkg, wtds_goal_if, wtds_cmd_if and waypoint_turn_then_drive_steps.
// Predicts the rotation and advance commands for each goal and checks them in order.
module waypoint_turn_then_drive_steps_tb;

	typedef struct {
		logic signed [31:0] left;
		logic signed [31:0] right;
		logic               adv;
	} wheel_cmd_t;

	// Tracks pose, heading and configuration; holds the commands still owed by the block.
	class drive_scoreboard;
		logic [23:0] spm;
		logic [9:0]  track;
		longint      px, py;
		logic [15:0] hdg;
		wheel_cmd_t  owed[$];
		int          errors;
		longint      atan_tab[16] = '{
			64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4,
			64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
			64'h0028BE53, 64'h00145F2E, 64'h000A2F98, 64'h000517CC,
			64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C};

		function void clear();
			spm = wtds_pkg::SPM_RESET;
			track = wtds_pkg::TRACK_RESET;
			px = 0;
			py = 0;
			hdg = 0;
			errors = 0;
		endfunction

		function void set_reg(logic idx, logic [23:0] val);
			if (idx == wtds_pkg::REG_STEPS_PER_MM)
				spm = val;
			else
				track = val[9:0];
		endfunction

		// Vectoring CORDIC, angle measured from +y toward +x
		function logic [15:0] bearing_of(longint dx, longint dy);
			longint u, v, acc, tmp, du, dv;
			u = dy <<< 42;
			v = dx <<< 42;
			acc = 0;
			if (u < 0) begin
				tmp = u;
				if (v >= 0) begin
					u = v;
					v = -tmp;
					acc = 64'sd1 <<< 30;
				end else begin
					u = -v;
					v = tmp;
					acc = -(64'sd1 <<< 30);
				end
			end
			for (int i = 0; i < 16; i++) begin
				du = v >>> i;
				dv = u >>> i;
				if (v >= 0) begin
					u += du;
					v -= dv;
					acc += atan_tab[i];
				end else begin
					u -= du;
					v += dv;
					acc -= atan_tab[i];
				end
			end
			acc = (acc + (64'sd1 <<< 15)) >>> 16;
			return acc[15:0];
		endfunction

		// floor(sqrt(dx^2+dy^2) * 2^16)
		function logic [63:0] dist_q16(longint dx, longint dy);
			logic [127:0] n, trial, root;
			n = 128'(dx * dx + dy * dy) << 32;
			root = 0;
			for (int k = 40; k >= 0; k--) begin
				trial = root | (128'd1 << k);
				if (trial * trial <= n)
					root = trial;
			end
			return root[63:0];
		endfunction

		function void note_goal(logic signed [15:0] gx, logic signed [15:0] gy);
			longint dx, dy;
			logic [15:0] turn;
			logic signed [15:0] t;
			logic [63:0] mag, b, mid, s, d, adv;
			logic [127:0] prod;
			wheel_cmd_t c;
			dx = longint'(gx) - px;
			dy = longint'(gy) - py;
			turn = 0;
			if (dx != 0 || dy != 0)
				turn = 16'(0) - bearing_of(dx, dy) - hdg;
			t = turn;
			mag = (t < 0) ? 64'(-longint'(t)) : 64'(t);
			b = mag * 64'(track) * 64'(spm);
			mid = (b >> 32) * 64'(wtds_pkg::PI_Q29)
				+ (((b & 64'hFFFFFFFF) * 64'(wtds_pkg::PI_Q29)) >> 32);
			s = mid >> 29;
			if (t < 0)
				s = 64'd0 - s;
			c.left = 32'(64'd0 - s);
			c.right = 32'(s);
			c.adv = 1'b0;
			owed.push_back(c);
			d = dist_q16(dx, dy);
			prod = 128'(d) * 128'(spm);
			prod = prod >> 32;
			adv = (prod > 128'h7FFFFFFF) ? 64'h7FFFFFFF : prod[63:0];
			c.left = 32'(adv);
			c.right = 32'(adv);
			c.adv = 1'b1;
			owed.push_back(c);
			hdg = hdg + turn;
			px = gx;
			py = gy;
		endfunction

		function void check_cmd(logic signed [31:0] l, logic signed [31:0] r, logic a);
			wheel_cmd_t e;
			if (owed.size() == 0) begin
				$error("unexpected command left_steps=%0d right_steps=%0d", l, r);
				errors++;
				return;
			end
			e = owed.pop_front();
			if (l !== e.left) begin
				$error("left_steps expected %0d actual %0d", e.left, l);
				errors++;
			end
			if (r !== e.right) begin
				$error("right_steps expected %0d actual %0d", e.right, r);
				errors++;
			end
			if (a !== e.adv) begin
				$error("is_advance expected %0b actual %0b", e.adv, a);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [23:0] cfg_data;
	int          hold_off_req;
	logic        rx_burst;
	longint      cycles;
	drive_scoreboard sb;

	wtds_goal_if goal_ch();
	wtds_cmd_if  cmd_ch();

	waypoint_turn_then_drive_steps u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.goal      (goal_ch),
		.cmd       (cmd_ch)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Abort on a runaway run
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 2000000) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// Accept commands with random stalls; honor long hold-off requests
	initial begin : cmd_sink
		int hold;
		hold = 0;
		rx_burst = 1'b0;
		cmd_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (cmd_ch.valid && cmd_ch.ready) begin
				sb.check_cmd(cmd_ch.left_steps, cmd_ch.right_steps, cmd_ch.is_advance);
				if ($urandom_range(0, 40) == 0)
					rx_burst = ~rx_burst;
				hold = rx_burst ? 0 : $urandom_range(0, 11);
			end
			if (hold_off_req > 0) begin
				hold = hold_off_req;
				hold_off_req = 0;
			end
			if (hold > 0) begin
				cmd_ch.ready <= 1'b0;
				hold--;
			end else begin
				cmd_ch.ready <= 1'b1;
			end
		end
	end

	task automatic wait_drained();
		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [23:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	// Offer one goal after the given gap and hold it until the transfer
	task automatic send_goal(logic signed [15:0] gx, logic signed [15:0] gy, int gap);
		if (gap > 0) begin
			goal_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		goal_ch.valid <= 1'b1;
		goal_ch.goal_x <= gx;
		goal_ch.goal_y <= gy;
		do @(posedge clk); while (!goal_ch.ready);
		sb.note_goal(gx, gy);
	endtask

	// Mostly short hops near the pose, some full-range jumps and repeated goals
	task automatic random_goals(int n);
		logic signed [15:0] gx, gy;
		bit burst;
		burst = 0;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					gx = 16'($urandom);
					gy = 16'($urandom);
				end
				2: begin
					gx = 16'(sb.px);
					gy = 16'(sb.py);
				end
				3: begin
					gx = 16'(sb.px);
					gy = 16'(sb.py + $signed($urandom_range(0, 2)) - 1);
				end
				default: begin
					gx = 16'(sb.px + $signed($urandom_range(0, 2000)) - 1000);
					gy = 16'(sb.py + $signed($urandom_range(0, 2000)) - 1000);
				end
			endcase
			if ($urandom_range(0, 30) == 0)
				burst = ~burst;
			send_goal(gx, gy, burst ? 0 : $urandom_range(0, 11));
		end
		goal_ch.valid <= 1'b0;
	endtask

	initial begin
		sb = new();
		sb.clear();
		hold_off_req = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = wtds_pkg::REG_STEPS_PER_MM;
		cfg_data = '0;
		goal_ch.valid = 1'b0;
		goal_ch.goal_x = '0;
		goal_ch.goal_y = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: zero offset, ahead, abeam, behind, coordinate extremes
		send_goal(0, 0, 0);
		send_goal(0, 100, 0);
		send_goal(50, 100, 3);
		send_goal(0, 100, 0);
		send_goal(50, 100, 0);
		send_goal(50, 100, 2);
		send_goal(16'sh7FFF, 16'sh7FFF, 0);
		send_goal(-16'sh8000, -16'sh8000, 0);
		send_goal(-16'sh8000, 16'sh7FFF, 1);
		send_goal(16'sh7FFF, -16'sh8000, 0);
		send_goal(16'sh7FFF, -16'sh8000, 0);
		send_goal(0, 0, 0);
		goal_ch.valid <= 1'b0;

		// Fill the block while the command side holds off
		wait_drained();
		hold_off_req = 400;
		random_goals(6);
		wait_drained();

		// Largest scale, widest track
		write_reg(wtds_pkg::REG_STEPS_PER_MM, 24'hFFFFFF);
		write_reg(wtds_pkg::REG_TRACK_WIDTH, 24'd1023);
		send_goal(16'sh7FFF, 16'sh7FFF, 0);
		send_goal(-16'sh8000, -16'sh8000, 0);
		random_goals(150);
		wait_drained();

		// Zero scale
		write_reg(wtds_pkg::REG_STEPS_PER_MM, 24'd0);
		random_goals(100);
		wait_drained();

		// Zero and unit track widths
		write_reg(wtds_pkg::REG_STEPS_PER_MM, 24'd65536);
		write_reg(wtds_pkg::REG_TRACK_WIDTH, 24'd0);
		random_goals(100);
		wait_drained();
		write_reg(wtds_pkg::REG_TRACK_WIDTH, 24'd1);
		random_goals(100);
		wait_drained();

		// Random settings
		for (int p = 0; p < 4; p++) begin
			write_reg(wtds_pkg::REG_STEPS_PER_MM, 24'($urandom_range(0, 24'hFFFFFF)));
			write_reg(wtds_pkg::REG_TRACK_WIDTH, 24'($urandom_range(1, 1023)));
			random_goals(120);
			wait_drained();
		end

		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
